FILE: hdl/ssvf_pkg.sv
// shared types and constants for the stereo state variable filter
// no dependencies; imported by ssvf_lane and stereo_state_variable_filter
`default_nettype none

package ssvf_pkg;

  // fixed-point formats
  localparam int SAMPLE_W  = 24;              // signed Q1.23 samples
  localparam int COEF_FRAC = 22;              // fraction bits of the coefficients
  localparam int COEF_W    = COEF_FRAC + 2;   // unsigned Q2.22 coefficients
  localparam int STATE_W   = 32;              // signed integrator states
  localparam int OPND_W    = STATE_W + 4;     // multiplier data operand
  localparam int PROD_W    = COEF_W + 1 + OPND_W;
  localparam int ACC_W     = STATE_W + 8;     // sums, v1, v2 and the output before saturation
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 3;
  localparam int CFG_W     = COEF_W;

  // register reset values
  localparam logic [COEF_W-1:0] A1_RESET = COEF_W'(64'd1 << COEF_FRAC);
  localparam logic [COEF_W-1:0] K_RESET  = COEF_W'(64'd2 << COEF_FRAC);

  // register indexes of the write port
  typedef enum logic [ADDR_W-1:0] {
    REG_A1   = 3'd0,
    REG_A2   = 3'd1,
    REG_A3   = 3'd2,
    REG_K    = 3'd3,
    REG_MODE = 3'd4
  } reg_idx_e;

  // response selected for the output
  typedef enum logic [MODE_W-1:0] {
    MODE_LOWPASS  = 2'd0,
    MODE_BANDPASS = 2'd1,
    MODE_HIGHPASS = 2'd2,
    MODE_NOTCH    = 2'd3
  } mode_e;

  // coefficient set shared by both lanes
  typedef struct packed {
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] a3;
    logic [COEF_W-1:0] k;
    mode_e             mode;
  } coef_t;

  // what a lane reports back to the merge stage
  typedef struct packed {
    logic                       done;
    logic                       clip;
    logic signed [SAMPLE_W-1:0] y;
  } lane_res_t;

endpackage

`default_nettype wire

FILE: hdl/ssvf_lane.sv
// one channel of the filter: two integrator states and a sequencer around one multiplier
// depends on ssvf_pkg
`default_nettype none

module ssvf_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [ssvf_pkg::SAMPLE_W-1:0] x_i,
  input  wire ssvf_pkg::coef_t                      coef_i,
  output ssvf_pkg::lane_res_t                       res_o
);
  import ssvf_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_A1S1   = 8'b0000_0010,
    ST_A2V3   = 8'b0000_0100,
    ST_A2S1   = 8'b0000_1000,
    ST_A3V3   = 8'b0001_0000,
    ST_KV1    = 8'b0010_0000,
    ST_RKV1   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } step_e;

  localparam logic signed [PROD_W-1:0] HALF      = PROD_W'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [ACC_W-1:0]  STATE_MAX = ACC_W'((64'sd1 <<< (STATE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  STATE_MIN = -STATE_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  SMP_MAX   = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  SMP_MIN   = -SMP_MAX - ACC_W'(1);

  // product / 2^COEF_FRAC, halves away from zero
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + HALF - PROD_W'(p < 0);
    return ACC_W'(s >>> COEF_FRAC);
  endfunction

  step_e                       st_q, st_d;
  logic signed [SAMPLE_W-1:0]  x_q;
  logic signed [OPND_W-1:0]    v3_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     v1_q, v2_q, kv1_q;
  logic signed [STATE_W-1:0]   s1_q, s2_q;
  logic signed [SAMPLE_W-1:0]  y_q;
  logic                        clip_q, done_q;

  logic [COEF_W-1:0]           mul_c;
  logic signed [OPND_W-1:0]    mul_v;
  logic signed [PROD_W-1:0]    prod_d;
  logic signed [ACC_W-1:0]     prod_rnd;
  logic signed [ACC_W-1:0]     ns1, ns2, y_full;
  logic signed [STATE_W-1:0]   s1_d, s2_d;
  logic signed [SAMPLE_W-1:0]  y_d;
  logic                        clip_d;

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (start_i) st_d = ST_A1S1;
      ST_A1S1:   st_d = ST_A2V3;
      ST_A2V3:   st_d = ST_A2S1;
      ST_A2S1:   st_d = ST_A3V3;
      ST_A3V3:   st_d = ST_KV1;
      ST_KV1:    st_d = ST_RKV1;
      ST_RKV1:   st_d = ST_FINISH;
      ST_FINISH: st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_c = coef_i.a1;
    mul_v = OPND_W'(s1_q);
    unique case (st_q)
      ST_A1S1: begin
        mul_c = coef_i.a1;
        mul_v = OPND_W'(s1_q);
      end
      ST_A2V3: begin
        mul_c = coef_i.a2;
        mul_v = v3_q;
      end
      ST_A2S1: begin
        mul_c = coef_i.a2;
        mul_v = OPND_W'(s1_q);
      end
      ST_A3V3: begin
        mul_c = coef_i.a3;
        mul_v = v3_q;
      end
      ST_KV1: begin
        mul_c = coef_i.k;
        mul_v = OPND_W'(v1_q);
      end
      default: begin
        mul_c = coef_i.a1;
        mul_v = OPND_W'(s1_q);
      end
    endcase
  end

  assign prod_d   = PROD_W'($signed({1'b0, mul_c}) * mul_v);
  assign prod_rnd = rnd(prod_q);

  // new states, output selection and saturation
  always_comb begin
    clip_d = 1'b0;
    ns1    = (v1_q <<< 1) - ACC_W'(s1_q);
    ns2    = (v2_q <<< 1) - ACC_W'(s2_q);
    case (coef_i.mode)
      MODE_LOWPASS:  y_full = v2_q;
      MODE_BANDPASS: y_full = v1_q;
      MODE_HIGHPASS: y_full = ACC_W'(x_q) - kv1_q - v2_q;
      default:       y_full = ACC_W'(x_q) - kv1_q;
    endcase

    if (ns1 > STATE_MAX) begin
      s1_d = STATE_W'(STATE_MAX); clip_d = 1'b1;
    end else if (ns1 < STATE_MIN) begin
      s1_d = STATE_W'(STATE_MIN); clip_d = 1'b1;
    end else begin
      s1_d = STATE_W'(ns1);
    end

    if (ns2 > STATE_MAX) begin
      s2_d = STATE_W'(STATE_MAX); clip_d = 1'b1;
    end else if (ns2 < STATE_MIN) begin
      s2_d = STATE_W'(STATE_MIN); clip_d = 1'b1;
    end else begin
      s2_d = STATE_W'(ns2);
    end

    if (y_full > SMP_MAX) begin
      y_d = SAMPLE_W'(SMP_MAX); clip_d = 1'b1;
    end else if (y_full < SMP_MIN) begin
      y_d = SAMPLE_W'(SMP_MIN); clip_d = 1'b1;
    end else begin
      y_d = SAMPLE_W'(y_full);
    end
  end

  // control state and integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      done_q <= 1'b0;
      s1_q   <= '0;
      s2_q   <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == ST_FINISH);
      if (st_q == ST_FINISH) begin
        s1_q <= s1_d;
        s2_q <= s2_d;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (st_q) inside
      ST_IDLE: begin
        x_q  <= x_i;
        v3_q <= OPND_W'(x_i) - OPND_W'(s2_q);
        v1_q <= '0;
        v2_q <= ACC_W'(s2_q);
      end
      ST_A2V3, ST_A2S1: v1_q <= v1_q + prod_rnd;
      ST_A3V3, ST_KV1:  v2_q <= v2_q + prod_rnd;
      ST_RKV1:          kv1_q <= prod_rnd;
      ST_FINISH: begin
        y_q    <= y_d;
        clip_q <= clip_d;
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.clip = clip_q;
  assign res_o.y    = y_q;

endmodule

`default_nettype wire

FILE: hdl/stereo_state_variable_filter.sv
// top level: configuration registers, two filter lanes and the merging output stage
// depends on ssvf_pkg and ssvf_lane
//
// Usage
//   Input stream: one stereo pair per word, s_axis_tdata = {right_in, left_in}.
//   Output stream: one word per input word, m_axis_tdata = {right_out, left_out},
//   m_axis_tuser = clipped (any state or output saturated for this pair).
//   Write port: cfg_we_i with cfg_addr_i 0..4 selects a1, a2, a3, k, mode;
//   other indexes are ignored. Write only while no pair is in flight.
//   Each channel runs in its own lane, which steps one multiplier through five
//   products; the dependent chain a1*s1, a2*v3, a2*s1, a3*v3, then k*v1, plus
//   rounding and the saturating state update, sets the pace.
//   A new pair is taken only once the previous result moves to the output register.
//   The output word waits in a register; if the receiver stalls, the next pair
//   is still taken and computed, and then held until the register frees up.
//   Reset clears the integrators, loads a1 = 1.0, a2 = a3 = 0, k = 2.0,
//   lowpass mode, and empties the output register.
`default_nettype none

module stereo_state_variable_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [2*ssvf_pkg::SAMPLE_W-1:0] s_axis_tdata,  // right_in, left_in
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [2*ssvf_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // right_out, left_out
  output logic                               m_axis_tuser,  // clipped
  // register write port
  input  wire logic                          cfg_we_i,
  input  wire logic [ssvf_pkg::ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [ssvf_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import ssvf_pkg::*;

  coef_t      coef_q;
  lane_res_t  res_l, res_r;
  logic       busy_q, pend_q, out_valid_q, out_clip_q;
  logic [2*SAMPLE_W-1:0] out_data_q;
  logic       accept, avail, xfer;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a1   <= A1_RESET;
      coef_q.a2   <= '0;
      coef_q.a3   <= '0;
      coef_q.k    <= K_RESET;
      coef_q.mode <= MODE_LOWPASS;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_A1:   coef_q.a1   <= cfg_wdata_i;
        REG_A2:   coef_q.a2   <= cfg_wdata_i;
        REG_A3:   coef_q.a3   <= cfg_wdata_i;
        REG_K:    coef_q.k    <= cfg_wdata_i;
        REG_MODE: coef_q.mode <= mode_e'(cfg_wdata_i[MODE_W-1:0]);
        default:  ;
      endcase
    end
  end

  // handshake: a lane result moves to the output register when it is free
  assign avail         = res_l.done || pend_q;
  assign xfer          = avail && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || xfer;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // both lanes start together and finish together
  ssvf_lane u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .x_i     ($signed(s_axis_tdata[SAMPLE_W-1:0])),
    .coef_i  (coef_q),
    .res_o   (res_l)
  );

  ssvf_lane u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .x_i     ($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
    .coef_i  (coef_q),
    .res_o   (res_r)
  );

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (xfer) begin
        busy_q <= 1'b0;
      end
      pend_q <= avail && !xfer;
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge stage: join the channels and the clip flags
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_data_q <= {res_r.y, res_l.y};
      out_clip_q <= res_l.clip | res_r.clip;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clip_q;

endmodule

`default_nettype wire
